[rtl/core/assert_macros.svh]
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PUVM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("puvm check failed");

// checked on every edge, reset included
`define PUVM_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("puvm reset check failed");

`endif

[rtl/core/puvm_pkg.sv]
// types, constants and helpers of the planar uv mapper
package puvm_pkg;

    localparam int IDX_W     = 12;
    localparam int IDX_RANGE = 4096;
    localparam int LIM_W     = 17;
    localparam int DATA_W    = 32;
    localparam int DIFF_W    = 33;
    localparam int PROD_W    = 66;
    localparam int FRAC_W    = 16;
    localparam int VCALC_W   = 51;
    localparam int CFG_IDX_W = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic signed [DATA_W-1:0]  ONE_Q16   = 32'sd65536;
    localparam logic signed [DATA_W-1:0]  ZERO_Q16  = 32'sd0;
    localparam logic signed [VCALC_W-1:0] ONE_WIDE  = 51'sd65536;
    localparam logic signed [VCALC_W-1:0] SAT_HI    = 51'sd2147483647;
    localparam logic signed [VCALC_W-1:0] SAT_LO    = -51'sd2147483648;

    localparam logic [CFG_IDX_W-1:0] CFG_RECT_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_BOTTOM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_HEIGHT  = 2'd3;

    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    typedef enum logic [1:0] {
        MODE_VERTEX    = 2'd0,
        MODE_FACE_INIT = 2'd1,
        MODE_TRI_ACC   = 2'd2,
        MODE_TRI_RES   = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_VOUT,
        S_INIT,
        S_RA,
        S_RB,
        S_RC,
        S_FWR,
        S_FRD,
        S_FOUT
    } t_state;

    typedef struct packed {
        logic signed [DATA_W-1:0] rect_left;
        logic signed [DATA_W-1:0] rect_bottom;
        logic [DATA_W-1:0]        inv_width;
        logic [DATA_W-1:0]        inv_height;
    } t_cfg;

    typedef struct packed {
        t_mode                    mode;
        logic [IDX_W-1:0]         vertex_index;
        logic                     vertex_ok;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [IDX_W-1:0]         corner_a;
        logic [IDX_W-1:0]         corner_b;
        logic [IDX_W-1:0]         corner_c;
        logic                     a_ok;
        logic                     b_ok;
        logic                     c_ok;
        logic [IDX_W-1:0]         face_index;
        logic                     face_ok;
        logic                     last;
    } t_item;

    function automatic logic idx_ok(input logic [IDX_W-1:0] idx,
                                    input logic [LIM_W-1:0] lim);
        return {{(LIM_W-IDX_W){1'b0}}, idx} < lim;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [VCALC_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > SAT_HI) begin
            r = 32'sh7FFFFFFF;
        end else if (x < SAT_LO) begin
            r = 32'sh80000000;
        end else begin
            r = $signed(x[DATA_W-1:0]);
        end
        return r;
    endfunction

endpackage

[rtl/core/puvm_front.sv]
// front end: accepts input words, checks index ranges, forms edge offsets
module puvm_front #(
    parameter int MAX_VERTICES = 4096,
    parameter int MAX_FACES    = 4096
) (
    input  puvm_pkg::t_cfg                       i_cfg,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [1:0]                           i_mode,
    input  logic [puvm_pkg::IDX_W-1:0]           i_vertex_index,
    input  logic signed [puvm_pkg::DATA_W-1:0]   i_pos_x,
    input  logic signed [puvm_pkg::DATA_W-1:0]   i_pos_y,
    input  logic [puvm_pkg::IDX_W-1:0]           i_corner_a,
    input  logic [puvm_pkg::IDX_W-1:0]           i_corner_b,
    input  logic [puvm_pkg::IDX_W-1:0]           i_corner_c,
    input  logic [puvm_pkg::IDX_W-1:0]           i_face_index,
    input  logic                                 i_last_item,
    input  logic                                 i_full,
    output logic                                 o_push,
    output puvm_pkg::t_item                      o_item
);

    localparam logic [puvm_pkg::LIM_W-1:0] VLIM = puvm_pkg::LIM_W'(MAX_VERTICES);
    localparam logic [puvm_pkg::LIM_W-1:0] FLIM = puvm_pkg::LIM_W'(MAX_FACES);

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_item              = '0;
        o_item.mode         = puvm_pkg::t_mode'(i_mode);
        o_item.vertex_index = i_vertex_index;
        o_item.vertex_ok    = puvm_pkg::idx_ok(i_vertex_index, VLIM);
        o_item.dx           = $signed({i_pos_x[31], i_pos_x})
                            - $signed({i_cfg.rect_left[31], i_cfg.rect_left});
        o_item.dy           = $signed({i_pos_y[31], i_pos_y})
                            - $signed({i_cfg.rect_bottom[31], i_cfg.rect_bottom});
        o_item.corner_a     = i_corner_a;
        o_item.corner_b     = i_corner_b;
        o_item.corner_c     = i_corner_c;
        o_item.a_ok         = puvm_pkg::idx_ok(i_corner_a, VLIM);
        o_item.b_ok         = puvm_pkg::idx_ok(i_corner_b, VLIM);
        o_item.c_ok         = puvm_pkg::idx_ok(i_corner_c, VLIM);
        o_item.face_index   = i_face_index;
        o_item.face_ok      = puvm_pkg::idx_ok(i_face_index, FLIM);
        o_item.last         = i_last_item;
    end

endmodule

[rtl/core/puvm_queue.sv]
// two-entry queue between front and back
module puvm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  puvm_pkg::t_item i_item,
    input  logic            i_pop,
    output puvm_pkg::t_item o_item,
    output logic            o_full,
    output logic            o_empty
);

    puvm_pkg::t_item                    r_mem [puvm_pkg::QUEUE_DEPTH];
    logic [puvm_pkg::QPTR_W-1:0]        r_wr_ptr;
    logic [puvm_pkg::QPTR_W-1:0]        r_rd_ptr;
    logic [puvm_pkg::QCNT_W-1:0]        r_count;

    assign o_item  = r_mem[r_rd_ptr];
    assign o_full  = r_count == puvm_pkg::QCNT_W'(puvm_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/core/puvm_back.sv]
// back end: multiplies, flag stores, face accumulate and output register
module puvm_back #(
    parameter int MAX_VERTICES = 4096,
    parameter int MAX_FACES    = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  puvm_pkg::t_cfg                     i_cfg,
    input  puvm_pkg::t_item                    i_head,
    input  logic                               i_empty,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_out_kind,
    output logic signed [puvm_pkg::DATA_W-1:0] o_out_u,
    output logic signed [puvm_pkg::DATA_W-1:0] o_out_v,
    output logic                               o_inside_flag,
    output logic                               o_triangle_valid,
    output logic                               o_out_last
);

    localparam int VDEPTH = (MAX_VERTICES < puvm_pkg::IDX_RANGE) ? MAX_VERTICES
                                                                 : puvm_pkg::IDX_RANGE;
    localparam int FDEPTH = (MAX_FACES < puvm_pkg::IDX_RANGE) ? MAX_FACES
                                                              : puvm_pkg::IDX_RANGE;
    localparam int VAW    = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
    localparam int FAW    = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;

    puvm_pkg::t_state                       r_state, n_state;
    puvm_pkg::t_item                        r_cur;
    logic                                   r_vmem [VDEPTH];
    logic                                   r_fmem [FDEPTH];
    logic                                   r_vrd;
    logic                                   r_frd;
    logic                                   r_acc;
    logic signed [puvm_pkg::PROD_W-1:0]     r_pu;
    logic signed [puvm_pkg::PROD_W-1:0]     r_pv;
    logic                                   r_out_valid;
    logic                                   r_kind;
    logic signed [puvm_pkg::DATA_W-1:0]     r_u;
    logic signed [puvm_pkg::DATA_W-1:0]     r_v;
    logic                                   r_inside;
    logic                                   r_tri;
    logic                                   r_last;

    logic [puvm_pkg::IDX_W-1:0]             vaddr;
    logic                                   vwe;
    logic                                   fwe;
    logic                                   fwd;
    logic                                   out_load;
    logic                                   out_free;
    logic signed [puvm_pkg::VCALC_W-1:0]    u_wide;
    logic signed [puvm_pkg::VCALC_W-1:0]    v_wide;
    logic signed [puvm_pkg::DATA_W-1:0]     u_sat;
    logic signed [puvm_pkg::DATA_W-1:0]     v_sat;
    logic                                   in_rect;

    assign out_free = !r_out_valid || i_ready;

    // dropping the low fraction bits of a two's complement product is a floor
    assign u_wide = $signed({r_pu[puvm_pkg::PROD_W-1], r_pu[puvm_pkg::PROD_W-1:puvm_pkg::FRAC_W]});
    assign v_wide = puvm_pkg::ONE_WIDE
                  - $signed({r_pv[puvm_pkg::PROD_W-1], r_pv[puvm_pkg::PROD_W-1:puvm_pkg::FRAC_W]});
    assign u_sat  = puvm_pkg::sat32(u_wide);
    assign v_sat  = puvm_pkg::sat32(v_wide);
    assign in_rect = (u_sat >= puvm_pkg::ZERO_Q16) && (u_sat <= puvm_pkg::ONE_Q16)
                  && (v_sat >= puvm_pkg::ZERO_Q16) && (v_sat <= puvm_pkg::ONE_Q16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= puvm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        vaddr    = r_cur.corner_a;
        vwe      = 1'b0;
        fwe      = 1'b0;
        fwd      = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            puvm_pkg::S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    unique case (i_head.mode)
                        puvm_pkg::MODE_VERTEX:    n_state = puvm_pkg::S_MUL;
                        puvm_pkg::MODE_FACE_INIT: n_state = puvm_pkg::S_INIT;
                        puvm_pkg::MODE_TRI_ACC:   n_state = puvm_pkg::S_RA;
                        puvm_pkg::MODE_TRI_RES:   n_state = puvm_pkg::S_FRD;
                        default:                  n_state = puvm_pkg::S_IDLE;
                    endcase
                end
            end
            puvm_pkg::S_MUL: begin
                n_state = puvm_pkg::S_VOUT;
            end
            puvm_pkg::S_VOUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    vwe      = r_cur.vertex_ok;
                    n_state  = puvm_pkg::S_IDLE;
                end
            end
            puvm_pkg::S_INIT: begin
                fwe     = r_cur.face_ok;
                fwd     = 1'b1;
                n_state = puvm_pkg::S_IDLE;
            end
            puvm_pkg::S_RA: begin
                vaddr   = r_cur.corner_a;
                n_state = puvm_pkg::S_RB;
            end
            puvm_pkg::S_RB: begin
                vaddr   = r_cur.corner_b;
                n_state = puvm_pkg::S_RC;
            end
            puvm_pkg::S_RC: begin
                vaddr   = r_cur.corner_c;
                n_state = puvm_pkg::S_FWR;
            end
            puvm_pkg::S_FWR: begin
                fwe     = r_cur.face_ok;
                fwd     = r_frd & r_acc & r_cur.c_ok & r_vrd;
                n_state = puvm_pkg::S_IDLE;
            end
            puvm_pkg::S_FRD: begin
                n_state = puvm_pkg::S_FOUT;
            end
            puvm_pkg::S_FOUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = puvm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = puvm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
        end
        if (r_state == puvm_pkg::S_MUL) begin
            r_pu <= $signed(r_cur.dx) * $signed({1'b0, i_cfg.inv_width});
            r_pv <= $signed(r_cur.dy) * $signed({1'b0, i_cfg.inv_height});
        end
        if (r_state == puvm_pkg::S_RB) begin
            r_acc <= r_cur.a_ok & r_vrd;
        end else if (r_state == puvm_pkg::S_RC) begin
            r_acc <= r_acc & r_cur.b_ok & r_vrd;
        end
    end

    // vertex inside flags
    always_ff @(posedge i_clk) begin
        if (vwe) begin
            r_vmem[r_cur.vertex_index[VAW-1:0]] <= in_rect;
        end
        r_vrd <= r_vmem[vaddr[VAW-1:0]];
    end

    // face valid flags
    always_ff @(posedge i_clk) begin
        if (fwe) begin
            r_fmem[r_cur.face_index[FAW-1:0]] <= fwd;
        end
        r_frd <= r_fmem[r_cur.face_index[FAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_state == puvm_pkg::S_VOUT) begin
                r_kind   <= puvm_pkg::KIND_VERTEX;
                r_u      <= u_sat;
                r_v      <= v_sat;
                r_inside <= in_rect;
                r_tri    <= 1'b0;
            end else begin
                r_kind   <= puvm_pkg::KIND_TRIANGLE;
                r_u      <= '0;
                r_v      <= '0;
                r_inside <= 1'b0;
                r_tri    <= r_cur.face_ok & r_frd;
            end
            r_last <= r_cur.last;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_out_kind       = r_kind;
    assign o_out_u          = r_u;
    assign o_out_v          = r_v;
    assign o_inside_flag    = r_inside;
    assign o_triangle_valid = r_tri;
    assign o_out_last       = r_last;

endmodule

[rtl/core/planar_uv_map_with_face_clip.sv]
// top level of the planar uv mapper with face clipping
// usage:
// - input channel i_valid/o_ready carries one word: mode, vertex and face
//   indexes, position and the last mark; output channel o_valid/i_ready
//   returns vertex coordinates or a face flag
// - configuration is written through i_cfg_we/i_cfg_index/i_cfg_data while idle
// - a front stage takes words into a two-entry queue, a back sequencer works
//   through them one at a time
// - back steps per word: vertex pops from the queue, multiplies, then
//   saturates and stores; face init pops and writes its flag; triangle
//   accumulate pops, makes three corner reads on the single vertex flag port,
//   then the face read-modify-write; face result pops, reads, then outputs
// - vertex and face result words produce a result, the other modes none
// - reset clears the queue, the sequencer and the output valid and loads
//   the register defaults; flag stores are not cleared and must be written
//   before they are read
// - when the receiver stalls the result holds in the output register, the
//   back stops before its next result and the queue fills, then o_ready drops
module planar_uv_map_with_face_clip #(
    parameter int MAX_VERTICES = 4096,
    parameter int MAX_FACES    = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [puvm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [puvm_pkg::DATA_W-1:0]            i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [1:0]                             i_mode,
    input  logic [puvm_pkg::IDX_W-1:0]             i_vertex_index,
    input  logic signed [puvm_pkg::DATA_W-1:0]     i_pos_x,
    input  logic signed [puvm_pkg::DATA_W-1:0]     i_pos_y,
    input  logic [puvm_pkg::IDX_W-1:0]             i_corner_a,
    input  logic [puvm_pkg::IDX_W-1:0]             i_corner_b,
    input  logic [puvm_pkg::IDX_W-1:0]             i_corner_c,
    input  logic [puvm_pkg::IDX_W-1:0]             i_face_index,
    input  logic                                   i_last_item,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic                                   o_out_kind,
    output logic signed [puvm_pkg::DATA_W-1:0]     o_out_u,
    output logic signed [puvm_pkg::DATA_W-1:0]     o_out_v,
    output logic                                   o_inside_flag,
    output logic                                   o_triangle_valid,
    output logic                                   o_out_last
);

    puvm_pkg::t_cfg  r_cfg;
    puvm_pkg::t_item push_item;
    puvm_pkg::t_item head_item;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rect_left   <= '0;
            r_cfg.rect_bottom <= '0;
            r_cfg.inv_width   <= puvm_pkg::ONE_Q16;
            r_cfg.inv_height  <= puvm_pkg::ONE_Q16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                puvm_pkg::CFG_RECT_LEFT:   r_cfg.rect_left   <= $signed(i_cfg_data);
                puvm_pkg::CFG_RECT_BOTTOM: r_cfg.rect_bottom <= $signed(i_cfg_data);
                puvm_pkg::CFG_INV_WIDTH:   r_cfg.inv_width   <= i_cfg_data;
                puvm_pkg::CFG_INV_HEIGHT:  r_cfg.inv_height  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    puvm_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_FACES    (MAX_FACES)
    ) u_front (
        .i_cfg          (r_cfg),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_vertex_index (i_vertex_index),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_corner_a     (i_corner_a),
        .i_corner_b     (i_corner_b),
        .i_corner_c     (i_corner_c),
        .i_face_index   (i_face_index),
        .i_last_item    (i_last_item),
        .i_full         (full),
        .o_push         (push),
        .o_item         (push_item)
    );

    puvm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_full  (full),
        .o_empty (empty)
    );

    puvm_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_FACES    (MAX_FACES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_head           (head_item),
        .i_empty          (empty),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_kind       (o_out_kind),
        .o_out_u          (o_out_u),
        .o_out_v          (o_out_v),
        .o_inside_flag    (o_inside_flag),
        .o_triangle_valid (o_triangle_valid),
        .o_out_last       (o_out_last)
    );

endmodule

[rtl/core/puvm_checker.sv]
// port-level checks of the uv mapper and their bind
`include "assert_macros.svh"

module puvm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic                                o_out_kind,
    input logic signed [puvm_pkg::DATA_W-1:0]  o_out_u,
    input logic signed [puvm_pkg::DATA_W-1:0]  o_out_v,
    input logic                                o_inside_flag,
    input logic                                o_triangle_valid,
    input logic                                o_out_last
);

    `PUVM_ASSERT_RST(a_reset_clears_valid, !i_rst_n |=> !o_valid)

    `PUVM_ASSERT(a_stall_holds, o_valid && !i_ready |=> o_valid && $stable(o_out_kind) && $stable(o_out_u) && $stable(o_out_v) && $stable(o_inside_flag) && $stable(o_triangle_valid) && $stable(o_out_last))

    `PUVM_ASSERT(a_tri_word_clean, o_valid && o_out_kind |-> o_out_u == 32'sd0 && o_out_v == 32'sd0 && !o_inside_flag)

    `PUVM_ASSERT(a_vtx_word_clean, o_valid && !o_out_kind |-> !o_triangle_valid)

    `PUVM_ASSERT(a_inside_in_unit, o_valid && !o_out_kind && o_inside_flag |-> o_out_u >= 32'sd0 && o_out_u <= 32'sd65536 && o_out_v >= 32'sd0 && o_out_v <= 32'sd65536)

endmodule

bind planar_uv_map_with_face_clip puvm_checker u_puvm_checker (.*);
